// ----- hw/rtl/st0_pkg.sv -----
// ----------------------------------------------------------------------------
// st0_pkg: shared definitions for the T=0 procedure engine
// Request codes, result kinds, error codes, phase type and fixed values.
// ----------------------------------------------------------------------------
`default_nettype none

package st0_pkg;

  // request operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_GRANT  = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_HEADER  = 3'd0;
  localparam logic [2:0] ERR_PROC    = 3'd1;
  localparam logic [2:0] ERR_TIMEOUT = 3'd2;
  localparam logic [2:0] ERR_EARLY   = 3'd3;
  localparam logic [2:0] ERR_BUSY    = 3'd4;

  // protocol bytes
  localparam logic [7:0] NULL_BYTE  = 8'h60;
  localparam logic [7:0] CLA_BAD    = 8'hFF;
  localparam logic [3:0] SW_NIBBLE6 = 4'h6;
  localparam logic [3:0] SW_NIBBLE9 = 4'h9;

  localparam logic [8:0]  HEADER_LEN      = 9'd5;
  localparam logic [8:0]  READ_LEN_ZERO   = 9'd256;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PROC = 2'd1,
    PH_SW2  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// ----- hw/rtl/st0_if.sv -----
// ----------------------------------------------------------------------------
// st0 channel interfaces
// Valid/ready channels for engine requests and engine results.
// ----------------------------------------------------------------------------
`default_nettype none

interface st0_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] cla;
  logic [7:0] ins;
  logic [7:0] p3;
  logic       has_data;
  logic [7:0] rx_byte;

  modport source (output valid, op, cla, ins, p3, has_data, rx_byte, input ready);
  modport sink (input valid, op, cla, ins, p3, has_data, rx_byte, output ready);
endinterface

interface st0_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [8:0] count;
  logic [7:0] data_byte;
  logic [7:0] sw1;
  logic [7:0] sw2;
  logic [2:0] error_code;

  modport source (output valid, kind, count, data_byte, sw1, sw2, error_code, input ready);
  modport sink (input valid, kind, count, data_byte, sw1, sw2, error_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/smartcard_t0_procedure_engine.sv -----
// ----------------------------------------------------------------------------
// smartcard_t0_procedure_engine
// Reader-side T=0 command exchange: header check, procedure bytes, timeout.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle. Each request is decoded against the
// current exchange state in a single pass of logic and its result, if any,
// lands in the output register on the same edge, visible in the next cycle.
// cmd.ready drops only while the output register holds a result not yet taken.
// The timeout register resets to 2000 ticks; the user writes it via cfg_we/
// cfg_wdata only while the engine is idle, which the block does not enforce.
`default_nettype none

module smartcard_t0_procedure_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  st0_cmd_if.sink          cmd,
  st0_res_if.source        res
);

  // exchange state
  st0_pkg::phase_t phase, phase_next;
  logic [7:0]  ins_code, ins_code_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [8:0]  chunk_left, chunk_left_next;
  logic        write_mode, write_mode_next;
  logic [7:0]  held_sw1, held_sw1_next;
  logic [8:0]  reply_count, reply_count_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [15:0] timeout_ticks;

  // result of the current request
  logic        emit;
  logic [2:0]  kind_next;
  logic [8:0]  count_next;
  logic [7:0]  data_next;
  logic [7:0]  sw1_next;
  logic [7:0]  sw2_next;
  logic [2:0]  err_next;

  logic        accept;
  logic        busy;
  logic        hdr_bad;
  logic        rx_null;
  logic        rx_sw;
  logic [7:0]  ack_x;
  logic        ack_all;
  logic        ack_one;
  logic [8:0]  grant;
  logic [15:0] ticks_inc;
  logic [15:0] limit;
  logic        expire;
  logic        early;
  logic [8:0]  chunk_dec;

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign busy      = phase != st0_pkg::PH_IDLE;

  // request decode
  assign hdr_bad = cmd.cla == st0_pkg::CLA_BAD || cmd.ins[7:4] == st0_pkg::SW_NIBBLE6
                   || cmd.ins[7:4] == st0_pkg::SW_NIBBLE9;
  assign rx_null = cmd.rx_byte == st0_pkg::NULL_BYTE;
  assign rx_sw   = cmd.rx_byte[7:4] == st0_pkg::SW_NIBBLE6
                   || cmd.rx_byte[7:4] == st0_pkg::SW_NIBBLE9;
  assign ack_x   = cmd.rx_byte ^ ins_code;
  assign ack_all = ack_x == 8'h00 || ack_x == 8'h01;
  assign ack_one = ack_x == 8'hFF || ack_x == 8'hFE;
  assign grant   = ack_all ? bytes_left : {8'd0, bytes_left != 9'd0};

  // tick and data counters
  assign ticks_inc = idle_ticks + 16'd1;
  assign limit     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign expire    = ticks_inc >= limit;
  assign early     = !write_mode && reply_count != 9'd0 && bytes_left != 9'd0;
  assign chunk_dec = chunk_left - {8'd0, chunk_left != 9'd0};

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      priority case (cmd.op)
        st0_pkg::OP_START: begin
          if (busy || hdr_bad) begin
            phase_next = st0_pkg::PH_IDLE;
          end else begin
            phase_next = st0_pkg::PH_PROC;
          end
        end
        st0_pkg::OP_TICK: begin
          if (busy && expire) phase_next = st0_pkg::PH_IDLE;
        end
        st0_pkg::OP_BYTE: begin
          unique case (phase)
            st0_pkg::PH_IDLE: phase_next = phase;
            st0_pkg::PH_DATA: begin
              if (chunk_dec == 9'd0) phase_next = st0_pkg::PH_PROC;
            end
            st0_pkg::PH_SW2: phase_next = st0_pkg::PH_IDLE;
            st0_pkg::PH_PROC: begin
              priority if (rx_null) begin
                phase_next = phase;
              end else if (rx_sw) begin
                phase_next = st0_pkg::PH_SW2;
              end else if (ack_all || ack_one) begin
                if (grant != 9'd0 && !write_mode) phase_next = st0_pkg::PH_DATA;
              end else begin
                phase_next = st0_pkg::PH_IDLE;
              end
            end
            default: phase_next = phase;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath updates and result
  always_comb begin
    ins_code_next    = ins_code;
    bytes_left_next  = bytes_left;
    chunk_left_next  = chunk_left;
    write_mode_next  = write_mode;
    held_sw1_next    = held_sw1;
    reply_count_next = reply_count;
    idle_ticks_next  = idle_ticks;
    emit       = 1'b0;
    kind_next  = st0_pkg::KIND_HEADER;
    count_next = 9'd0;
    data_next  = 8'd0;
    sw1_next   = 8'd0;
    sw2_next   = 8'd0;
    err_next   = st0_pkg::ERR_HEADER;
    if (accept) begin
      priority case (cmd.op)
        st0_pkg::OP_START: begin
          emit = 1'b1;
          if (busy || hdr_bad) begin
            chunk_left_next = 9'd0;
            idle_ticks_next = 16'd0;
            kind_next       = st0_pkg::KIND_ERROR;
            err_next        = busy ? st0_pkg::ERR_BUSY : st0_pkg::ERR_HEADER;
          end else begin
            write_mode_next  = cmd.has_data;
            ins_code_next    = cmd.ins;
            bytes_left_next  = (!cmd.has_data && cmd.p3 == 8'd0) ? st0_pkg::READ_LEN_ZERO
                                                                 : {1'b0, cmd.p3};
            chunk_left_next  = 9'd0;
            reply_count_next = 9'd0;
            held_sw1_next    = 8'd0;
            idle_ticks_next  = 16'd0;
            count_next       = st0_pkg::HEADER_LEN;
          end
        end
        st0_pkg::OP_TICK: begin
          if (busy) begin
            idle_ticks_next = ticks_inc;
            if (expire) begin
              emit            = 1'b1;
              chunk_left_next = 9'd0;
              idle_ticks_next = 16'd0;
              kind_next       = st0_pkg::KIND_ERROR;
              err_next        = st0_pkg::ERR_TIMEOUT;
            end
          end
        end
        st0_pkg::OP_BYTE: begin
          if (busy) idle_ticks_next = 16'd0;
          unique case (phase)
            st0_pkg::PH_IDLE: emit = 1'b0;
            st0_pkg::PH_DATA: begin
              emit             = 1'b1;
              reply_count_next = reply_count + 9'd1;
              bytes_left_next  = bytes_left - {8'd0, bytes_left != 9'd0};
              chunk_left_next  = chunk_dec;
              kind_next        = st0_pkg::KIND_DATA;
              data_next        = cmd.rx_byte;
            end
            st0_pkg::PH_SW2: begin
              emit = 1'b1;
              if (early) begin
                chunk_left_next = 9'd0;
                kind_next       = st0_pkg::KIND_ERROR;
                err_next        = st0_pkg::ERR_EARLY;
              end else begin
                bytes_left_next = 9'd0;
                kind_next       = st0_pkg::KIND_DONE;
                count_next      = reply_count + 9'd2;
                sw1_next        = held_sw1;
                sw2_next        = cmd.rx_byte;
              end
            end
            st0_pkg::PH_PROC: begin
              priority if (rx_null) begin
                emit = 1'b0;
              end else if (rx_sw) begin
                held_sw1_next = cmd.rx_byte;
              end else if (ack_all || ack_one) begin
                if (grant != 9'd0) begin
                  if (write_mode) begin
                    emit            = 1'b1;
                    bytes_left_next = bytes_left - grant;
                    kind_next       = st0_pkg::KIND_GRANT;
                    count_next      = grant;
                  end else begin
                    chunk_left_next = grant;
                  end
                end
              end else begin
                emit            = 1'b1;
                chunk_left_next = 9'd0;
                idle_ticks_next = 16'd0;
                kind_next       = st0_pkg::KIND_ERROR;
                err_next        = st0_pkg::ERR_PROC;
              end
            end
            default: emit = 1'b0;
          endcase
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= st0_pkg::PH_IDLE;
      ins_code      <= 8'd0;
      bytes_left    <= 9'd0;
      chunk_left    <= 9'd0;
      write_mode    <= 1'b0;
      held_sw1      <= 8'd0;
      reply_count   <= 9'd0;
      idle_ticks    <= 16'd0;
      timeout_ticks <= st0_pkg::TIMEOUT_DEFAULT;
    end else begin
      phase       <= phase_next;
      ins_code    <= ins_code_next;
      bytes_left  <= bytes_left_next;
      chunk_left  <= chunk_left_next;
      write_mode  <= write_mode_next;
      held_sw1    <= held_sw1_next;
      reply_count <= reply_count_next;
      idle_ticks  <= idle_ticks_next;
      if (cfg_we) timeout_ticks <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.ready) begin
      res.valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready) begin
      res.kind       <= kind_next;
      res.count      <= count_next;
      res.data_byte  <= data_next;
      res.sw1        <= sw1_next;
      res.sw2        <= sw2_next;
      res.error_code <= err_next;
    end
  end

  // checks
  a_reset_idle: assert property (@(posedge clk) rst |=> phase == st0_pkg::PH_IDLE)
    else $error("phase not idle after reset");

  a_data_chunk: assert property (@(posedge clk) disable iff (rst)
    phase == st0_pkg::PH_DATA |-> chunk_left != 9'd0)
    else $error("data phase with empty chunk");

  a_idle_ticks: assert property (@(posedge clk) disable iff (rst)
    phase == st0_pkg::PH_IDLE |-> idle_ticks == 16'd0)
    else $error("tick count left over while idle");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == st0_pkg::KIND_GRANT |-> res.count != 9'd0 && write_mode)
    else $error("empty or read-side data grant");

endmodule

`default_nettype wire

// ----- verif/smartcard_t0_procedure_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smartcard_t0_procedure_engine_tb: self-checking bench for the T=0 engine
// A short directed table covers header rejects, busy starts, NULL bytes,
// full and single-byte grants, the 256-byte read, early status and quiet ticks.
// Random exchanges follow under several timeout settings. Each result is
// compared against a cycle-free model of the exchange kept in this bench.
// ----------------------------------------------------------------------------

module smartcard_t0_procedure_engine_tb;

  // op value with no meaning to the engine
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // ack byte classes after xor with INS, bit 0 dropped
  localparam logic [6:0] ACK_SAME = 7'h00;
  localparam logic [6:0] ACK_INV  = 7'h7F;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned PRINT_CAP    = 100;
  localparam int unsigned QUIET_TICKS  = 20;
  localparam int unsigned STEP_CAP     = 64;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cla;
    logic [7:0] ins;
    logic [7:0] p3;
    logic       has_data;
    logic [7:0] rx_byte;
  } t0_req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [8:0] count;
    logic [7:0] data_byte;
    logic [7:0] sw1;
    logic [7:0] sw2;
    logic [2:0] error_code;
  } t0_res_t;

  typedef struct {
    t0_req_t     req;
    int unsigned reps;
    bit          typed;
    t0_res_t     want;
  } plan_row_t;

  typedef enum {RCV_OPEN, RCV_SPOTTY, RCV_CHOKED} rcv_mode_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  st0_cmd_if cmd_ch ();
  st0_res_if res_ch ();

  smartcard_t0_procedure_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // exchange model state
  st0_pkg::phase_t ex_phase;
  logic [7:0]  ex_ins;
  logic [8:0]  ex_left;
  logic [8:0]  ex_chunk;
  logic [8:0]  ex_replies;
  logic        ex_write;
  logic [7:0]  ex_sw1;
  logic [15:0] ex_quiet;
  logic [15:0] ex_timeout;

  t0_res_t     results_due[$];
  plan_row_t   plan[$];
  int unsigned mismatches;
  int unsigned req_total;
  int unsigned burst_left;
  rcv_mode_t   rcv_mode = RCV_OPEN;
  int unsigned rcv_seg_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit is_status(input logic [7:0] b);
    return b[7:4] == st0_pkg::SW_NIBBLE6 || b[7:4] == st0_pkg::SW_NIBBLE9;
  endfunction

  function automatic void abort_exchange(output t0_res_t o, input logic [2:0] code);
    ex_phase   = st0_pkg::PH_IDLE;
    ex_chunk   = '0;
    ex_quiet   = '0;
    o          = '0;
    o.kind       = st0_pkg::KIND_ERROR;
    o.error_code = code;
  endfunction

  // advance the exchange model by one request; returns 1 when a result is due
  function automatic bit t0_exchange_step(input t0_req_t r, output t0_res_t o);
    logic [7:0]  x;
    logic [8:0]  grant;
    logic [15:0] lim;
    o   = '0;
    x   = r.rx_byte ^ ex_ins;
    lim = (ex_timeout == '0) ? 16'd1 : ex_timeout;
    case (r.op)
      st0_pkg::OP_START: begin
        if (ex_phase != st0_pkg::PH_IDLE) begin
          abort_exchange(o, st0_pkg::ERR_BUSY);
          return 1'b1;
        end
        if (r.cla == st0_pkg::CLA_BAD || is_status(r.ins)) begin
          abort_exchange(o, st0_pkg::ERR_HEADER);
          return 1'b1;
        end
        ex_write   = r.has_data;
        ex_ins     = r.ins;
        ex_left    = (!r.has_data && r.p3 == '0) ? st0_pkg::READ_LEN_ZERO : {1'b0, r.p3};
        ex_chunk   = '0;
        ex_replies = '0;
        ex_sw1     = '0;
        ex_quiet   = '0;
        ex_phase   = st0_pkg::PH_PROC;
        o.kind  = st0_pkg::KIND_HEADER;
        o.count = st0_pkg::HEADER_LEN;
        return 1'b1;
      end
      st0_pkg::OP_TICK: begin
        if (ex_phase == st0_pkg::PH_IDLE) return 1'b0;
        ex_quiet = ex_quiet + 16'd1;
        if (ex_quiet >= lim) begin
          abort_exchange(o, st0_pkg::ERR_TIMEOUT);
          return 1'b1;
        end
        return 1'b0;
      end
      st0_pkg::OP_BYTE: ;
      default: return 1'b0;
    endcase

    if (ex_phase == st0_pkg::PH_IDLE) return 1'b0;
    ex_quiet = '0;
    case (ex_phase)
      // granted read data passes through
      st0_pkg::PH_DATA: begin
        ex_replies = ex_replies + 9'd1;
        if (ex_left != '0) ex_left = ex_left - 9'd1;
        if (ex_chunk != '0) ex_chunk = ex_chunk - 9'd1;
        if (ex_chunk == '0) ex_phase = st0_pkg::PH_PROC;
        o.kind      = st0_pkg::KIND_DATA;
        o.data_byte = r.rx_byte;
        return 1'b1;
      end
      // second status byte closes the exchange
      st0_pkg::PH_SW2: begin
        if (!ex_write && ex_replies != '0 && ex_left != '0) begin
          abort_exchange(o, st0_pkg::ERR_EARLY);
          return 1'b1;
        end
        ex_phase = st0_pkg::PH_IDLE;
        ex_left  = '0;
        o.kind  = st0_pkg::KIND_DONE;
        o.count = ex_replies + 9'd2;
        o.sw1   = ex_sw1;
        o.sw2   = r.rx_byte;
        return 1'b1;
      end
      // procedure byte
      default: begin
        if (r.rx_byte == st0_pkg::NULL_BYTE) return 1'b0;
        if (is_status(r.rx_byte)) begin
          ex_sw1   = r.rx_byte;
          ex_phase = st0_pkg::PH_SW2;
          return 1'b0;
        end
        if (x[7:1] == ACK_SAME) begin
          grant = ex_left;
        end else if (x[7:1] == ACK_INV) begin
          grant = (ex_left != '0) ? 9'd1 : 9'd0;
        end else begin
          abort_exchange(o, st0_pkg::ERR_PROC);
          return 1'b1;
        end
        if (grant == '0) return 1'b0;
        if (ex_write) begin
          ex_left = ex_left - grant;
          o.kind  = st0_pkg::KIND_GRANT;
          o.count = grant;
          return 1'b1;
        end
        ex_chunk = grant;
        ex_phase = st0_pkg::PH_DATA;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic t0_req_t mk_req(input logic [1:0] op, input logic [7:0] cla,
                                     input logic [7:0] ins, input logic [7:0] p3,
                                     input logic wr, input logic [7:0] rx);
    t0_req_t r;
    r.op       = op;
    r.cla      = cla;
    r.ins      = ins;
    r.p3       = p3;
    r.has_data = wr;
    r.rx_byte  = rx;
    return r;
  endfunction

  function automatic t0_res_t mk_res(input logic [2:0] kind, input logic [8:0] count,
                                     input logic [7:0] data, input logic [7:0] s1,
                                     input logic [7:0] s2, input logic [2:0] code);
    t0_res_t w;
    w.kind       = kind;
    w.count      = count;
    w.data_byte  = data;
    w.sw1        = s1;
    w.sw2        = s2;
    w.error_code = code;
    return w;
  endfunction

  function automatic t0_req_t rand_req();
    t0_req_t r;
    r.op       = 2'($urandom);
    r.cla      = 8'($urandom);
    r.ins      = 8'($urandom);
    r.p3       = 8'($urandom);
    r.has_data = 1'($urandom);
    r.rx_byte  = 8'($urandom);
    return r;
  endfunction

  // a byte that is neither NULL, status nor any ack for the current INS
  function automatic logic [7:0] bad_proc_byte();
    if (!is_status(ex_ins ^ 8'h10)) return ex_ins ^ 8'h10;
    if (!is_status(ex_ins ^ 8'h20)) return ex_ins ^ 8'h20;
    return ex_ins ^ 8'h40;
  endfunction

  function automatic void row_typed(input t0_req_t r, input t0_res_t w);
    plan.push_back('{r, 1, 1'b1, w});
  endfunction

  function automatic void row_pred(input t0_req_t r, input int unsigned reps);
    plan.push_back('{r, reps, 1'b0, t0_res_t'('0)});
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // drive one request in bursts with random gaps, then log what it should cause
  task automatic send_req(input t0_req_t r, input bit typed, input t0_res_t want);
    t0_res_t     pred;
    bit          hit;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.op       <= r.op;
    cmd_ch.cla      <= r.cla;
    cmd_ch.ins      <= r.ins;
    cmd_ch.p3       <= r.p3;
    cmd_ch.has_data <= r.has_data;
    cmd_ch.rx_byte  <= r.rx_byte;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    req_total++;
    hit = t0_exchange_step(r, pred);
    if (typed) results_due.push_back(want);
    else if (hit) results_due.push_back(pred);
  endtask

  task automatic wait_results_drained();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // end any open exchange, let the engine go quiet, then write the timeout
  task automatic write_timeout(input logic [15:0] ticks);
    t0_req_t r;
    while (ex_phase != st0_pkg::PH_IDLE) begin
      r = rand_req();
      r.op = st0_pkg::OP_BYTE;
      if (ex_phase == st0_pkg::PH_PROC) r.rx_byte = bad_proc_byte();
      send_req(r, 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we     <= 1'b0;
    ex_timeout  = ticks;
    burst_left  = 0;
  endtask

  // one random exchange, mostly well formed, with noise mixed in
  task automatic run_random_exchange();
    t0_req_t     r;
    int unsigned steps;
    int unsigned roll;
    bit          silent;
    // stray requests while idle
    if ($urandom_range(0, 5) == 0) begin
      r = rand_req();
      if (r.op == st0_pkg::OP_START) r.op = OP_UNUSED;
      send_req(r, 1'b0, '0);
    end
    r = rand_req();
    r.op = st0_pkg::OP_START;
    if ($urandom_range(0, 15) == 0) r.cla = st0_pkg::CLA_BAD;
    if ($urandom_range(0, 9) == 0) begin
      r.ins[7:4] = ($urandom_range(0, 1) != 0) ? st0_pkg::SW_NIBBLE6 : st0_pkg::SW_NIBBLE9;
    end else begin
      while (is_status(r.ins)) r.ins = 8'($urandom);
    end
    case ($urandom_range(0, 39))
      0: r.p3 = 8'h00;
      1: r.p3 = 8'hFF;
      2: ;
      default: r.p3 = 8'($urandom_range(1, 6));
    endcase
    send_req(r, 1'b0, '0);

    silent = ($urandom_range(0, 19) == 0);
    steps  = 0;
    while (ex_phase != st0_pkg::PH_IDLE && steps < STEP_CAP) begin
      steps++;
      r    = rand_req();
      r.op = st0_pkg::OP_BYTE;
      roll = $urandom_range(0, 99);
      if (silent && steps < 40) begin
        r.op = st0_pkg::OP_TICK;
      end else begin
        case (ex_phase)
          st0_pkg::PH_PROC: begin
            if (roll < 6) r.op = st0_pkg::OP_TICK;
            else if (roll < 12) r.rx_byte = st0_pkg::NULL_BYTE;
            else if (roll < 15) r.op = st0_pkg::OP_START;
            else if (roll < 20) ;
            else if (roll < 38)
              r.rx_byte[7:4] = ($urandom_range(0, 1) != 0) ? st0_pkg::SW_NIBBLE6
                                                           : st0_pkg::SW_NIBBLE9;
            else if (roll < 70) r.rx_byte = ex_ins ^ 8'($urandom_range(0, 1));
            else r.rx_byte = ~(ex_ins ^ 8'($urandom_range(0, 1)));
          end
          st0_pkg::PH_DATA: begin
            if (roll < 4) r.op = st0_pkg::OP_TICK;
            else if (roll < 6) r.op = st0_pkg::OP_START;
          end
          default: begin
            if (roll < 5) r.op = st0_pkg::OP_TICK;
          end
        endcase
      end
      send_req(r, 1'b0, '0);
    end
  endtask

  // receiver stall pattern: segments that are open, spotty or choked
  always @(posedge clk) begin
    if (rcv_seg_left == 0) begin
      rcv_mode     <= rcv_mode_t'($urandom_range(0, 2));
      rcv_seg_left <= $urandom_range(20, 200);
    end else begin
      rcv_seg_left <= rcv_seg_left - 1;
    end
    case (rcv_mode)
      RCV_OPEN:   res_ch.ready <= 1'b1;
      RCV_SPOTTY: res_ch.ready <= 1'($urandom_range(0, 1));
      default:    res_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // compare each taken result with the oldest one due
  always @(posedge clk) begin
    t0_res_t w;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result kind %0h with none due", res_ch.kind));
      end else begin
        w = results_due.pop_front();
        check_field("kind", 9'(res_ch.kind), 9'(w.kind));
        check_field("count", res_ch.count, w.count);
        check_field("data_byte", 9'(res_ch.data_byte), 9'(w.data_byte));
        check_field("sw1", 9'(res_ch.sw1), 9'(w.sw1));
        check_field("sw2", 9'(res_ch.sw2), 9'(w.sw2));
        check_field("error_code", 9'(res_ch.error_code), 9'(w.error_code));
      end
    end
  end

  // main sequence
  initial begin
    logic [15:0] settings[4];
    int unsigned target;
    t0_res_t     hdr;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.op       <= st0_pkg::OP_TICK;
    cmd_ch.cla      <= '0;
    cmd_ch.ins      <= '0;
    cmd_ch.p3       <= '0;
    cmd_ch.has_data <= 1'b0;
    cmd_ch.rx_byte  <= '0;
    mismatches       = 0;
    req_total        = 0;
    burst_left       = 0;

    ex_phase   = st0_pkg::PH_IDLE;
    ex_ins     = '0;
    ex_left    = '0;
    ex_chunk   = '0;
    ex_replies = '0;
    ex_write   = 1'b0;
    ex_sw1     = '0;
    ex_quiet   = '0;
    ex_timeout = st0_pkg::TIMEOUT_DEFAULT;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, run with the reset timeout
    hdr = mk_res(st0_pkg::KIND_HEADER, st0_pkg::HEADER_LEN, '0, '0, '0, '0);
    // header rejects and ignored requests
    row_typed(mk_req(st0_pkg::OP_START, st0_pkg::CLA_BAD, 8'hA4, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_HEADER));
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'h6A, 8'h01, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_HEADER));
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'h9F, 8'h01, 1'b1, 8'h00),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_HEADER));
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF), 1);
    row_pred(mk_req(st0_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), 1);
    row_pred(mk_req(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF), 1);
    // start while busy
    row_typed(mk_req(st0_pkg::OP_START, 8'hFE, 8'hB0, 8'h00, 1'b0, 8'h00), hdr);
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'h00, 8'h01, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_BUSY));
    // read of 256 after NULL, acked with INS^1
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'hB0, 8'h00, 1'b0, 8'h00), hdr);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, st0_pkg::NULL_BYTE), 1);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hB1), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_DATA, '0, 8'h00, '0, '0, '0));
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hA5), 254);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF),
              mk_res(st0_pkg::KIND_DATA, '0, 8'hFF, '0, '0, '0));
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h90), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_DONE, 9'd258, '0, 8'h90, 8'h00, '0));
    // write with single-byte then full grant, then acks with nothing left
    row_typed(mk_req(st0_pkg::OP_START, 8'h80, 8'hFF, 8'hFF, 1'b1, 8'h00), hdr);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_GRANT, 9'd1, '0, '0, '0, '0));
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFE),
              mk_res(st0_pkg::KIND_GRANT, 9'd254, '0, '0, '0, '0));
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF), 1);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h01), 1);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h6F), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF),
              mk_res(st0_pkg::KIND_DONE, 9'd2, '0, 8'h6F, 8'hFF, '0));
    // status after partial read data
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'hC0, 8'h04, 1'b0, 8'h00), hdr);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h3F), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h11),
              mk_res(st0_pkg::KIND_DATA, '0, 8'h11, '0, '0, '0));
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h61), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_EARLY));
    // status before any read data completes normally
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'hC0, 8'h02, 1'b0, 8'h00), hdr);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h62), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h83),
              mk_res(st0_pkg::KIND_DONE, 9'd2, '0, 8'h62, 8'h83, '0));
    // bad procedure byte
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'h00, 8'h01, 1'b1, 8'h00), hdr);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h55),
              mk_res(st0_pkg::KIND_ERROR, '0, '0, '0, '0, st0_pkg::ERR_PROC));
    // quiet card stays well inside the default timeout, then ends normally
    row_typed(mk_req(st0_pkg::OP_START, 8'h00, 8'h20, 8'h01, 1'b0, 8'h00), hdr);
    row_pred(mk_req(st0_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00), QUIET_TICKS);
    row_pred(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h90), 1);
    row_typed(mk_req(st0_pkg::OP_BYTE, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00),
              mk_res(st0_pkg::KIND_DONE, 9'd2, '0, 8'h90, 8'h00, '0));

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_req(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random exchanges under several timeout settings
    settings[0] = 16'd1;
    settings[1] = 16'hFFFF;
    settings[2] = 16'd5;
    settings[3] = 16'($urandom_range(2, 40));
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      target = req_total + RANDOM_ITEMS / 4;
      while (req_total < target) run_random_exchange();
    end

    cmd_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
